// ===== sv/rational_arith_unit_defines.svh =====
// assertion macros used by the checker file
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define RAU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/rau_pkg.sv =====
package rau_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int IN_W          = 32;
    localparam int W             = 64;
    localparam int RED_W         = 33;
    localparam int DEN_OUT_W     = 63;
    localparam int CNT_W         = 6;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_GCD, S_GCD_W, S_DIVN, S_DIVN_W,
        S_DIVD, S_DIVD_W, S_MUL, S_COMB, S_OUT
    } t_state;

    typedef enum logic [1:0] {PH_A, PH_B, PH_F} t_phase;

    typedef enum logic [1:0] {G_IDLE, G_RUN, G_SHL} t_gcd_state;

    typedef enum logic {D_IDLE, D_RUN} t_div_state;

    // sign extend the low operand bits to the working width
    function automatic logic signed [W-1:0] sext_op(input logic [IN_W-1:0] v);
        return signed'({{(W-OPERAND_WIDTH){v[OPERAND_WIDTH-1]}}, v[OPERAND_WIDTH-1:0]});
    endfunction

    // absolute value as unsigned, most negative value maps to 2^(W-1)
    function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

endpackage

// ===== sv/rau_if.sv =====
interface rau_in_if;
    import rau_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [2:0]              req_type;
    logic signed [IN_W-1:0]  a_numerator;
    logic signed [IN_W-1:0]  a_denominator;
    logic signed [IN_W-1:0]  b_numerator;
    logic signed [IN_W-1:0]  b_denominator;
    modport source(output valid, req_type, a_numerator, a_denominator,
                   b_numerator, b_denominator, input ready);
    modport sink(input valid, req_type, a_numerator, a_denominator,
                 b_numerator, b_denominator, output ready);
endinterface

interface rau_out_if;
    import rau_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [W-1:0]     result_numerator;
    logic [DEN_OUT_W-1:0]    result_denominator;
    logic [1:0]              status;
    modport source(output valid, result_numerator, result_denominator, status,
                   input ready);
    modport sink(input valid, result_numerator, result_denominator, status,
                 output ready);
endinterface

// ===== sv/rau_gcd.sv =====
module rau_gcd (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [rau_pkg::W-1:0] i_x,
    input  logic [rau_pkg::W-1:0] i_y,
    output logic                  o_done,
    output logic [rau_pkg::W-1:0] o_g
);
    import rau_pkg::*;

    t_gcd_state       r_state, n_state;
    logic [W-1:0]     r_x, n_x, r_y, n_y, r_g, n_g;
    logic [CNT_W-1:0] r_sh, n_sh;
    logic             r_done, n_done;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            G_IDLE: if (i_start) n_state = G_RUN;
            G_RUN: begin
                if (r_x == '0) n_state = G_IDLE;
                else if (r_y == '0) n_state = G_SHL;
            end
            G_SHL: if (r_sh == '0) n_state = G_IDLE;
            default: n_state = G_IDLE;
        endcase
    end

    // binary gcd step: one shift or one compare and subtract per cycle
    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_sh   = r_sh;
        n_g    = r_g;
        n_done = 1'b0;
        unique case (r_state)
            G_IDLE: begin
                if (i_start) begin
                    n_x  = i_x;
                    n_y  = i_y;
                    n_sh = '0;
                end
            end
            G_RUN: begin
                if (r_x == '0) begin
                    n_g    = r_y;
                    n_done = 1'b1;
                end else if (r_y == '0) begin
                    n_sh = r_sh;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x  = r_x >> 1;
                    n_y  = r_y >> 1;
                    n_sh = r_sh + 1'b1;
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (r_x > r_y) begin
                    n_x = r_y;
                    n_y = r_x - r_y;
                end else begin
                    n_y = r_y - r_x;
                end
            end
            G_SHL: begin
                if (r_sh == '0) begin
                    n_g    = r_x;
                    n_done = 1'b1;
                end else begin
                    n_x  = r_x << 1;
                    n_sh = r_sh - 1'b1;
                end
            end
            default: n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= G_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_x  <= n_x;
        r_y  <= n_y;
        r_sh <= n_sh;
        r_g  <= n_g;
    end

    assign o_done = r_done;
    assign o_g    = r_g;
endmodule

// ===== sv/rau_div.sv =====
module rau_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [rau_pkg::W-1:0] i_num,
    input  logic [rau_pkg::W-1:0] i_den,
    output logic                  o_done,
    output logic [rau_pkg::W-1:0] o_quot
);
    import rau_pkg::*;

    t_div_state       r_state, n_state;
    logic [W-1:0]     r_rem, n_rem, r_q, n_q, r_den, n_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [W:0]       rem_sh;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE: if (i_start) n_state = D_RUN;
            D_RUN:  if (r_cnt == '1) n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    // restoring division, one quotient bit per cycle
    always_comb begin
        n_rem  = r_rem;
        n_q    = r_q;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_done = 1'b0;
        rem_sh = {r_rem, r_q[W-1]};
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_rem = '0;
                    n_q   = i_num;
                    n_den = i_den;
                    n_cnt = '0;
                end
            end
            D_RUN: begin
                if (rem_sh >= {1'b0, r_den}) begin
                    n_rem = W'(rem_sh - {1'b0, r_den});
                    n_q   = {r_q[W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[W-1:0];
                    n_q   = {r_q[W-2:0], 1'b0};
                end
                n_cnt  = r_cnt + 1'b1;
                n_done = (r_cnt == '1);
            end
            default: n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        r_den <= n_den;
        r_cnt <= n_cnt;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

// ===== sv/rational_arith_unit.sv =====
// sequence: an operand error goes straight to the output; otherwise reduce takes one
// reduction and the binary ops take three (a, b and the result), each a binary gcd (one
// shift or subtract per cycle) and two divisions, with three products and one combine step
// between the second and third
// throughput: one item at a time; a new item is accepted only in idle
// reset: synchronous active low, returns to idle with no result pending
module rational_arith_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    import rau_pkg::*;

    t_state                 r_state, n_state;
    t_phase                 r_phase, n_phase;
    logic [2:0]             r_op, n_op;
    logic signed [W-1:0]    r_bn, n_bn, r_bd, n_bd, r_wn, n_wn, r_wd, n_wd;
    logic [W-1:0]           r_g, n_g, r_mn, n_mn;
    logic signed [RED_W-1:0] r_xn, n_xn, r_xd, n_xd, r_yn, n_yn, r_yd, n_yd;
    logic signed [W-1:0]    r_p0, n_p0, r_p1, n_p1, r_p2, n_p2;
    logic [1:0]             r_mcnt, n_mcnt;
    logic signed [W-1:0]    r_fnum, n_fnum;
    logic [DEN_OUT_W-1:0]   r_fden, n_fden;
    logic [1:0]             r_fstat, n_fstat;
    logic                   r_ovalid;
    logic signed [W-1:0]    r_onum;
    logic [DEN_OUT_W-1:0]   r_oden;
    logic [1:0]             r_ostat;

    logic                   acc, in_bin, op_bin, out_free;
    logic signed [W-1:0]    an, ad, bn, bd;
    logic                   gcd_start, gcd_done, div_start, div_done;
    logic [W-1:0]           gcd_g, div_q, div_num;
    logic                   neg;
    logic [W-1:0]           red_num;
    logic signed [RED_W-1:0] ma, mb;
    logic signed [2*RED_W-1:0] prod;

    assign acc      = i_in.valid && i_in.ready;
    assign an       = sext_op(i_in.a_numerator);
    assign ad       = sext_op(i_in.a_denominator);
    assign bn       = sext_op(i_in.b_numerator);
    assign bd       = sext_op(i_in.b_denominator);
    assign in_bin   = (i_in.req_type <= OP_DIV);
    assign op_bin   = (r_op <= OP_DIV);
    assign out_free = !r_ovalid || o_out.ready;

    // shared gcd and divider
    assign gcd_start = (r_state == S_GCD);
    assign div_start = (r_state == S_DIVN) || (r_state == S_DIVD);
    assign div_num   = (r_state == S_DIVN) ? mag(r_wn) : mag(r_wd);

    rau_gcd u_gcd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(gcd_start),
        .i_x(mag(r_wn)), .i_y(mag(r_wd)), .o_done(gcd_done), .o_g(gcd_g)
    );

    rau_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(r_g), .o_done(div_done), .o_quot(div_q)
    );

    // sign goes to the numerator, zero is always positive
    assign neg     = (r_wn[W-1] ^ r_wd[W-1]) && (r_mn != '0);
    assign red_num = neg ? (~r_mn + 1'b1) : r_mn;

    // multiplier operand select, one product per cycle
    always_comb begin
        ma = r_yd;
        mb = r_xn;
        case (r_mcnt)
            2'd0: begin
                unique case (r_op) inside
                    OP_ADD, OP_SUB: begin ma = r_yd; mb = r_xn; end
                    OP_MUL:         begin ma = r_xn; mb = r_yn; end
                    default:        begin ma = r_xn; mb = r_yd; end
                endcase
            end
            2'd1: begin
                ma = r_xd;
                mb = r_yn;
            end
            default: begin
                unique case (r_op) inside
                    OP_ADD, OP_SUB: begin ma = r_yd; mb = r_xd; end
                    OP_MUL:         begin ma = r_xd; mb = r_yd; end
                    default:        begin ma = r_xd; mb = r_yn; end
                endcase
            end
        endcase
    end
    assign prod = ma * mb;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (ad == '0 || (in_bin && bd == '0)) n_state = S_OUT;
                    else if (i_in.req_type == OP_DIV && bn == '0) n_state = S_OUT;
                    else n_state = S_GCD;
                end
            end
            S_GCD:    n_state = S_GCD_W;
            S_GCD_W:  if (gcd_done) n_state = S_DIVN;
            S_DIVN:   n_state = S_DIVN_W;
            S_DIVN_W: if (div_done) n_state = S_DIVD;
            S_DIVD:   n_state = S_DIVD_W;
            S_DIVD_W: begin
                if (div_done) begin
                    unique case (r_phase)
                        PH_A:    n_state = op_bin ? S_GCD : S_OUT;
                        PH_B:    n_state = S_MUL;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_MUL:  if (r_mcnt == 2'd2) n_state = S_COMB;
            S_COMB: n_state = S_GCD;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath register updates
    always_comb begin
        n_phase = r_phase; n_op = r_op; n_bn = r_bn; n_bd = r_bd;
        n_wn = r_wn; n_wd = r_wd; n_g = r_g; n_mn = r_mn;
        n_xn = r_xn; n_xd = r_xd; n_yn = r_yn; n_yd = r_yd;
        n_p0 = r_p0; n_p1 = r_p1; n_p2 = r_p2; n_mcnt = r_mcnt;
        n_fnum = r_fnum; n_fden = r_fden; n_fstat = r_fstat;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_op    = i_in.req_type;
                    n_wn    = an;
                    n_wd    = ad;
                    n_bn    = bn;
                    n_bd    = bd;
                    n_phase = PH_A;
                    n_fnum  = '0;
                    n_fden  = '0;
                    if (ad == '0 || (in_bin && bd == '0)) n_fstat = ST_ZERO_DEN;
                    else if (i_in.req_type == OP_DIV && bn == '0) n_fstat = ST_DIV_ZERO;
                    else n_fstat = ST_OK;
                end
            end
            S_GCD_W:  if (gcd_done) n_g = gcd_g;
            S_DIVN_W: if (div_done) n_mn = div_q;
            S_DIVD_W: begin
                if (div_done) begin
                    unique case (r_phase)
                        PH_A: begin
                            n_xn = signed'(red_num[RED_W-1:0]);
                            n_xd = signed'(div_q[RED_W-1:0]);
                            n_wn = r_bn;
                            n_wd = r_bd;
                            n_phase = PH_B;
                            n_fnum  = signed'(red_num);
                            n_fden  = div_q[DEN_OUT_W-1:0];
                        end
                        PH_B: begin
                            n_yn   = signed'(red_num[RED_W-1:0]);
                            n_yd   = signed'(div_q[RED_W-1:0]);
                            n_mcnt = 2'd0;
                        end
                        default: begin
                            n_fnum = signed'(red_num);
                            n_fden = div_q[DEN_OUT_W-1:0];
                        end
                    endcase
                end
            end
            S_MUL: begin
                case (r_mcnt)
                    2'd0:    n_p0 = prod[W-1:0];
                    2'd1:    n_p1 = prod[W-1:0];
                    default: n_p2 = prod[W-1:0];
                endcase
                n_mcnt = r_mcnt + 2'd1;
            end
            S_COMB: begin
                unique case (r_op)
                    OP_ADD:  n_wn = r_p0 + r_p1;
                    OP_SUB:  n_wn = r_p0 - r_p1;
                    default: n_wn = r_p0;
                endcase
                n_wd    = r_p2;
                n_phase = PH_F;
            end
            default: n_mcnt = r_mcnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
        r_phase <= n_phase; r_op <= n_op; r_bn <= n_bn; r_bd <= n_bd;
        r_wn <= n_wn; r_wd <= n_wd; r_g <= n_g; r_mn <= n_mn;
        r_xn <= n_xn; r_xd <= n_xd; r_yn <= n_yn; r_yd <= n_yd;
        r_p0 <= n_p0; r_p1 <= n_p1; r_p2 <= n_p2; r_mcnt <= n_mcnt;
        r_fnum <= n_fnum; r_fden <= n_fden; r_fstat <= n_fstat;
        // output register
        if (r_state == S_OUT && out_free) begin
            r_onum  <= r_fnum;
            r_oden  <= r_fden;
            r_ostat <= r_fstat;
        end
    end

    assign i_in.ready               = (r_state == S_IDLE);
    assign o_out.valid              = r_ovalid;
    assign o_out.result_numerator   = r_onum;
    assign o_out.result_denominator = r_oden;
    assign o_out.status             = r_ostat;
endmodule

// ===== sv/rau_checker.sv =====
`include "rational_arith_unit_defines.svh"

module rau_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic signed [rau_pkg::W-1:0]  i_out_num,
    input logic [rau_pkg::DEN_OUT_W-1:0] i_out_den,
    input logic [1:0]                    i_out_status
);
    import rau_pkg::*;

    // result valid held while stalled
    `RAU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    // busy after a transfer in
    `RAU_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "ready right after transfer")
    // good result has a positive denominator
    `RAU_ASSERT_NOW(a_den_pos, i_clk, i_rst_n, i_out_valid && i_out_status == ST_OK, i_out_den != '0, "zero denominator on ok result")
    // error result is all zero
    `RAU_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, i_out_valid && i_out_status != ST_OK, i_out_num == '0 && i_out_den == '0, "nonzero error result")
endmodule

bind rational_arith_unit rau_checker u_rau_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid),
    .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_out_num(o_out.result_numerator),
    .i_out_den(o_out.result_denominator),
    .i_out_status(o_out.status)
);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import rau_pkg::*;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
    } t_req;

    typedef struct packed {
        logic [63:0] num;
        logic [62:0] den;
        logic [1:0]  status;
    } t_frac_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rau_in_if  in_ch();
    rau_out_if out_ch();

    rational_arith_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always #2 i_clk = ~i_clk;

    t_req        pending_reqs[$];
    t_frac_res   expected_fracs[$];
    int          src_idle_pct = 23;
    int          snk_idle_pct = 73;
    bit          hold_src     = 1'b0;
    bit          stim_done    = 1'b0;
    int          n_errors     = 0;
    int          n_results    = 0;
    int          n_status[3];

    // binary gcd on magnitudes
    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        int sh;
        logic [63:0] t;
        sh = 0;
        if (x == 0) return y;
        if (y == 0) return x;
        while (((x | y) & 64'd1) == 0) begin
            x = x >> 1;
            y = y >> 1;
            sh++;
        end
        while (!x[0]) x = x >> 1;
        while (y != 0) begin
            while (!y[0]) y = y >> 1;
            if (x > y) begin
                t = x;
                x = y;
                y = t;
            end
            y = y - x;
        end
        return x << sh;
    endfunction

    // lowest terms, sign carried by the numerator
    function automatic void lowest_terms(input logic signed [63:0] n,
                                         input logic signed [63:0] d,
                                         output logic signed [63:0] on,
                                         output logic [63:0] od);
        logic [63:0] mn, md, g;
        bit neg;
        mn = n[63] ? -n : n;
        md = d[63] ? -d : d;
        g = gcd64(mn, md);
        neg = n[63] != d[63];
        mn = mn / g;
        md = md / g;
        if (mn == 0) neg = 0;
        on = neg ? -mn : mn;
        od = md;
    endfunction

    function automatic t_frac_res rational_result(t_req r);
        t_frac_res res;
        logic signed [63:0] an, ad, bn, bd, xn, xd, yn, yd, rn, rd, on;
        logic [63:0] tmp, od;
        bit binary;
        an = {{32{r.an[31]}}, r.an};
        ad = {{32{r.ad[31]}}, r.ad};
        bn = {{32{r.bn[31]}}, r.bn};
        bd = {{32{r.bd[31]}}, r.bd};
        binary = r.req_type <= OP_DIV;
        res = '0;
        yn = 0;
        yd = 1;
        if (ad == 0 || (binary && bd == 0)) begin
            res.status = ST_ZERO_DEN;
            return res;
        end
        if (r.req_type == OP_DIV && bn == 0) begin
            res.status = ST_DIV_ZERO;
            return res;
        end
        lowest_terms(an, ad, xn, tmp);
        xd = tmp;
        if (binary) begin
            lowest_terms(bn, bd, yn, tmp);
            yd = tmp;
        end
        case (r.req_type)
            OP_ADD: begin
                rn = yd * xn + xd * yn;
                rd = yd * xd;
            end
            OP_SUB: begin
                rn = yd * xn - xd * yn;
                rd = yd * xd;
            end
            OP_MUL: begin
                rn = xn * yn;
                rd = xd * yd;
            end
            OP_DIV: begin
                rn = xn * yd;
                rd = xd * yn;
            end
            default: begin
                rn = xn;
                rd = xd;
            end
        endcase
        lowest_terms(rn, rd, on, od);
        res.num = on;
        res.den = od[62:0];
        res.status = ST_OK;
        return res;
    endfunction

    // driver: present queued items, random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_fracs.push_back(rational_result(pending_reqs.pop_front()));
            end
            if ((!in_ch.valid || in_ch.ready) ) begin
                if (!in_ch.valid || in_ch.ready) begin
                    if (pending_reqs.size() > (in_ch.valid && in_ch.ready ? 0 : 0) &&
                        !hold_src && $urandom_range(99) >= src_idle_pct) begin
                        in_ch.valid         <= 1'b1;
                        in_ch.req_type      <= pending_reqs[0].req_type;
                        in_ch.a_numerator   <= pending_reqs[0].an;
                        in_ch.a_denominator <= pending_reqs[0].ad;
                        in_ch.b_numerator   <= pending_reqs[0].bn;
                        in_ch.b_denominator <= pending_reqs[0].bd;
                    end else begin
                        in_ch.valid <= 1'b0;
                    end
                end
            end
        end
    end

    // monitor: compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_frac_res exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_fracs.size() == 0) begin
                    $error("unexpected result transfer");
                    n_errors++;
                end else begin
                    exp_r = expected_fracs.pop_front();
                    n_results++;
                    if (exp_r.status < 3) n_status[exp_r.status]++;
                    if (out_ch.result_numerator !== exp_r.num) begin
                        $error("result_numerator exp %0d got %0d",
                               $signed(exp_r.num), out_ch.result_numerator);
                        n_errors++;
                    end
                    if (out_ch.result_denominator !== exp_r.den) begin
                        $error("result_denominator exp %0d got %0d",
                               exp_r.den, out_ch.result_denominator);
                        n_errors++;
                    end
                    if (out_ch.status !== exp_r.status) begin
                        $error("status exp %0d got %0d", exp_r.status, out_ch.status);
                        n_errors++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.req_type = '0;
        in_ch.a_numerator = '0;
        in_ch.a_denominator = '0;
        in_ch.b_numerator = '0;
        in_ch.b_denominator = '0;
        out_ch.ready = 1'b0;
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(5))
            0: return $urandom_range(20) - 10;
            1: return {$urandom_range(1) ? 1'b1 : 1'b0, 31'd0} | $urandom_range(1);
            2: return $urandom_range(1) ? 32'h7fffffff : 32'h80000001;
            3: return ($urandom_range(1000) - 500) * (1 << $urandom_range(20));
            default: return $urandom();
        endcase
    endfunction

    task automatic add_req(input logic [2:0] op, input logic [31:0] an, input logic [31:0] ad,
                           input logic [31:0] bn, input logic [31:0] bd);
        t_req r;
        r.req_type = op;
        r.an = an;
        r.ad = ad;
        r.bn = bn;
        r.bd = bd;
        pending_reqs.push_back(r);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || in_ch.valid || expected_fracs.size() != 0)
            @(posedge i_clk);
    endtask

    // stimulus
    initial begin
        logic [31:0] d;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed corners
        add_req(OP_ADD, 1, 2, 1, 3);
        add_req(OP_SUB, 1, 2, 1, 2);
        add_req(OP_MUL, -2, 4, 3, -9);
        add_req(OP_DIV, 3, 4, -3, 8);
        add_req(4, 6, -4, 0, 0);
        add_req(4, 0, 0, 5, 5);
        add_req(OP_ADD, 1, 0, 1, 1);
        add_req(OP_MUL, 1, 1, 1, 0);
        add_req(OP_DIV, 1, 2, 0, 5);
        add_req(OP_DIV, 0, 2, 0, 0);
        add_req(5, 10, 20, 1, 0);
        add_req(6, -7, 14, 0, 0);
        add_req(7, 32'h80000000, 32'h80000000, 0, 0);
        add_req(OP_ADD, 32'h80000000, 1, 32'h80000000, 1);
        add_req(OP_SUB, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
        add_req(OP_MUL, 32'h80000000, 1, 32'h80000000, 1);
        add_req(OP_DIV, 32'h80000000, 32'h7fffffff, 1, 32'h80000000);
        add_req(OP_ADD, 0, -5, 0, 7);
        add_req(OP_DIV, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        add_req(OP_MUL, 32'h7fffffff, 32'h7ffffffe, 32'h7ffffffd, 32'h7fffffff);
        // sender holds off mid-stream until every result is back
        repeat (2) @(posedge i_clk);
        hold_src = 1'b1;
        while (in_ch.valid || expected_fracs.size() != 0) @(posedge i_clk);
        add_req(OP_ADD, 5, 6, 7, 8);
        repeat (50) @(posedge i_clk);
        hold_src = 1'b0;
        wait_drained();
        for (int ph = 0; ph < 3; ph++) begin
            src_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 73 : 0;
            snk_idle_pct = (ph == 0) ? 73 : (ph == 1) ? 23 : 0;
            for (int i = 0; i < 510; i++) begin
                d = rand_operand();
                if (d == 0 && $urandom_range(9) != 0) d = 1;
                add_req(3'($urandom_range(7)), rand_operand(), d, rand_operand(),
                        ($urandom_range(15) == 0) ? 32'd0 : rand_operand() | 32'd1);
                while (pending_reqs.size() > 4) @(posedge i_clk);
            end
            wait_drained();
        end
        repeat (20) @(posedge i_clk);
        $display("covered %0d results: %0d ok, %0d zero denominator, %0d divide by zero",
                 n_results, n_status[0], n_status[1], n_status[2]);
        if (n_errors == 0 && expected_fracs.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/rau_pkg.sv
sv/rau_if.sv
sv/rau_gcd.sv
sv/rau_div.sv
sv/rational_arith_unit.sv
sv/rau_checker.sv
bench/tb_top.sv
